FILE: hw/rtl/cbhe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbhe_pkg
// Shared types and constants for the CBOR item head encoder.
// ----------------------------------------------------------------------------
package cbhe_pkg;

  typedef enum logic [4:0] {
    OP_UINT        = 5'd0,
    OP_SINT        = 5'd1,
    OP_F32         = 5'd2,
    OP_F64         = 5'd3,
    OP_BOOL        = 5'd4,
    OP_NULL        = 5'd5,
    OP_UNDEF       = 5'd6,
    OP_BYTES       = 5'd7,
    OP_TEXT        = 5'd8,
    OP_TAG         = 5'd9,
    OP_BREAK       = 5'd10,
    OP_INDEF_TEXT  = 5'd11,
    OP_INDEF_BYTES = 5'd12,
    OP_MAP         = 5'd13,
    OP_INDEF_MAP   = 5'd14,
    OP_ARRAY       = 5'd15,
    OP_INDEF_ARRAY = 5'd16,
    OP_RAW         = 5'd17
  } op_t;

  // major type in the top three bits
  localparam logic [7:0] MT_UINT  = 8'h00;
  localparam logic [7:0] MT_NEG   = 8'h20;
  localparam logic [7:0] MT_BYTES = 8'h40;
  localparam logic [7:0] MT_TEXT  = 8'h60;
  localparam logic [7:0] MT_ARRAY = 8'h80;
  localparam logic [7:0] MT_MAP   = 8'hA0;
  localparam logic [7:0] MT_TAG   = 8'hC0;

  // additional info for 1, 2, 4 and 8 argument bytes
  localparam logic [4:0] AI_ARG1 = 5'd24;
  localparam logic [4:0] AI_ARG2 = 5'd25;
  localparam logic [4:0] AI_ARG4 = 5'd26;
  localparam logic [4:0] AI_ARG8 = 5'd27;

  localparam logic [7:0] HB_FALSE       = 8'hF4;
  localparam logic [7:0] HB_TRUE        = 8'hF5;
  localparam logic [7:0] HB_NULL        = 8'hF6;
  localparam logic [7:0] HB_UNDEF       = 8'hF7;
  localparam logic [7:0] HB_F32         = 8'hFA;
  localparam logic [7:0] HB_F64         = 8'hFB;
  localparam logic [7:0] HB_BREAK       = 8'hFF;
  localparam logic [7:0] HB_INDEF_TEXT  = 8'h7F;
  localparam logic [7:0] HB_INDEF_BYTES = 8'h5F;
  localparam logic [7:0] HB_INDEF_MAP   = 8'hBF;
  localparam logic [7:0] HB_INDEF_ARRAY = 8'h9F;

  // one classified request: head byte, argument left aligned, argument length
  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] arg;
    logic [3:0]  nbytes;
  } cmd_t;

endpackage

FILE: hw/rtl/cbhe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbhe_front
// Classifies a request into head byte, aligned argument and argument length.
// ----------------------------------------------------------------------------
module cbhe_front import cbhe_pkg::*; (
  input  logic [4:0]  operation,
  input  logic [63:0] value,
  output cmd_t        cmd,
  output logic        keep
);

  logic        is_head;
  logic [7:0]  major;
  logic [63:0] harg;

  always_comb begin
    cmd     = '0;
    keep    = 1'b1;
    is_head = 1'b0;
    major   = MT_UINT;
    harg    = value;
    case (op_t'(operation))
      OP_UINT: begin
        is_head = 1'b1;
      end
      OP_SINT: begin
        is_head = 1'b1;
        if (value[63]) begin
          major = MT_NEG;
          harg  = ~value;
        end
      end
      OP_F32: begin
        cmd.head   = HB_F32;
        cmd.arg    = {value[31:0], 32'h0};
        cmd.nbytes = 4'd4;
      end
      OP_F64: begin
        cmd.head   = HB_F64;
        cmd.arg    = value;
        cmd.nbytes = 4'd8;
      end
      OP_BOOL:        cmd.head = (value != 64'h0) ? HB_TRUE : HB_FALSE;
      OP_NULL:        cmd.head = HB_NULL;
      OP_UNDEF:       cmd.head = HB_UNDEF;
      OP_BYTES: begin
        is_head = 1'b1;
        major   = MT_BYTES;
      end
      OP_TEXT: begin
        is_head = 1'b1;
        major   = MT_TEXT;
      end
      OP_TAG: begin
        is_head = 1'b1;
        major   = MT_TAG;
      end
      OP_BREAK:       cmd.head = HB_BREAK;
      OP_INDEF_TEXT:  cmd.head = HB_INDEF_TEXT;
      OP_INDEF_BYTES: cmd.head = HB_INDEF_BYTES;
      OP_MAP: begin
        is_head = 1'b1;
        major   = MT_MAP;
      end
      OP_INDEF_MAP:   cmd.head = HB_INDEF_MAP;
      OP_ARRAY: begin
        is_head = 1'b1;
        major   = MT_ARRAY;
      end
      OP_INDEF_ARRAY: cmd.head = HB_INDEF_ARRAY;
      OP_RAW:         cmd.head = value[7:0];
      default:        keep = 1'b0;
    endcase

    if (is_head) begin
      if (harg[63:32] != 32'h0) begin
        cmd.head   = major | {3'b000, AI_ARG8};
        cmd.arg    = harg;
        cmd.nbytes = 4'd8;
      end else if (harg[31:16] != 16'h0) begin
        cmd.head   = major | {3'b000, AI_ARG4};
        cmd.arg    = {harg[31:0], 32'h0};
        cmd.nbytes = 4'd4;
      end else if (harg[15:8] != 8'h0) begin
        cmd.head   = major | {3'b000, AI_ARG2};
        cmd.arg    = {harg[15:0], 48'h0};
        cmd.nbytes = 4'd2;
      end else if (harg[7:0] >= 8'd24) begin
        cmd.head   = major | {3'b000, AI_ARG1};
        cmd.arg    = {harg[7:0], 56'h0};
        cmd.nbytes = 4'd1;
      end else begin
        cmd.head   = major | {3'b000, harg[4:0]};
        cmd.arg    = '0;
        cmd.nbytes = 4'd0;
      end
    end
  end

endmodule

FILE: hw/rtl/cbhe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbhe_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module cbhe_queue import cbhe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance");

endmodule

FILE: hw/rtl/cbhe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbhe_back
// Serializes one request per head byte plus argument bytes, MSB first.
// ----------------------------------------------------------------------------
module cbhe_back import cbhe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       q_cmd,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  logic        busy_r, busy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] arg_r, arg_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        adv;

  assign adv   = !valid_r || !out_stall;
  assign q_pop = adv && !busy_r && !q_empty;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    arg_nxt   = arg_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (adv) begin
      if (busy_r) begin
        valid_nxt = 1'b1;
        byte_nxt  = arg_r[63:56];
        last_nxt  = (cnt_r == 4'd1);
        arg_nxt   = {arg_r[55:0], 8'h0};
        cnt_nxt   = cnt_r - 4'd1;
        busy_nxt  = (cnt_r != 4'd1);
      end else if (!q_empty) begin
        valid_nxt = 1'b1;
        byte_nxt  = q_cmd.head;
        last_nxt  = (q_cmd.nbytes == 4'd0);
        arg_nxt   = q_cmd.arg;
        cnt_nxt   = q_cmd.nbytes;
        busy_nxt  = (q_cmd.nbytes != 4'd0);
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arg_r  <= arg_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r == 4'd0))
    else $error("byte count left over when idle");

  a_busy_shows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (valid_r && !last_r))
    else $error("item in flight without a pending non-last byte");

  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !last_r) |-> busy_r)
    else $error("non-last byte with nothing left to send");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy_r && !q_empty))
    else $error("pop while serializing");

endmodule

FILE: hw/rtl/cbor_item_head_encoder.sv
`timescale 1ns / 1ps
// The first byte of an accepted request passes through the request queue and the output register before it is valid.
// Throughput: one output byte per cycle unless out_stall holds the output or no
// request is waiting; a request yields 1 + argument bytes (1, 2, 3, 5 or 9).
// Input accepts while the request queue has room, also while output stalls.
// Reset: synchronous active-low rst_n empties the queue and the output stage.
// ----------------------------------------------------------------------------
// cbor_item_head_encoder
// CBOR (RFC 8949) data item head encoder, one byte per cycle out when not stalled.
// ----------------------------------------------------------------------------
module cbor_item_head_encoder import cbhe_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_operation,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

  cmd_t f_cmd;
  logic f_keep;
  cmd_t q_cmd;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;

  cbhe_front u_front (
    .operation (in_operation),
    .value     (in_value),
    .cmd       (f_cmd),
    .keep      (f_keep)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && f_keep;

  cbhe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (f_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  cbhe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_cmd         (q_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
